// File: rtl/lsq_pkg.sv
// -----------------------------------------------------------------------------
// lsq_pkg
// Shared types, widths and helpers for the largest square of ones block.
// -----------------------------------------------------------------------------
`default_nettype none

package lsq_pkg;

	localparam int MAX_COLS  = 1024;
	localparam int MAX_ROWS  = 1024;
	localparam int SIDE_W    = 11;
	localparam int POS_W     = 10;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

	typedef enum logic {
		ST_PRIME,
		ST_RUN
	} scan_state_t;

	// Scan position and grid shape as seen by the datapath
	typedef struct packed {
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
		logic              first_row;
		logic              first_col;
		logic              last_row;
		logic              last_col;
		logic [SIDE_W-1:0] num_rows;
		logic [SIDE_W-1:0] num_cols;
	} scan_pos_t;

	function automatic logic [SIDE_W-1:0] clamp_size(input logic [SIDE_W-1:0] v,
		input logic [SIDE_W-1:0] limit);
		logic [SIDE_W-1:0] r;
		r = v;
		if (v == '0)
			r = SIDE_W'(1);
		else if (v > limit)
			r = limit;
		return r;
	endfunction

	function automatic logic [SIDE_W-1:0] min3(input logic [SIDE_W-1:0] a,
		input logic [SIDE_W-1:0] b, input logic [SIDE_W-1:0] c);
		logic [SIDE_W-1:0] m;
		m = a;
		if (b < m)
			m = b;
		if (c < m)
			m = c;
		return m;
	endfunction

endpackage

`default_nettype wire

// File: rtl/lsq_line_mem.sv
// -----------------------------------------------------------------------------
// lsq_line_mem
// Line memory holding the sides of the previous row, one entry per column.
// One write and one read port; read data registered, write data forwarded.
// -----------------------------------------------------------------------------
`default_nettype none

module lsq_line_mem (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [lsq_pkg::POS_W-1:0]  wr_addr,
	input  wire logic [lsq_pkg::SIDE_W-1:0] wr_data,
	input  wire logic                       rd_en,
	input  wire logic [lsq_pkg::POS_W-1:0]  rd_addr,
	output logic      [lsq_pkg::SIDE_W-1:0] rd_data
);

	logic [lsq_pkg::SIDE_W-1:0] mem [0:lsq_pkg::MAX_COLS-1];
	logic [lsq_pkg::SIDE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// Hold the last read until the next one; bypass a write to the same entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr))
				rd_data_q <= wr_data;
			else
				rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/lsq_scan_ctrl.sv
// -----------------------------------------------------------------------------
// lsq_scan_ctrl
// Grid shape registers, row/column scan counters and the read-prime sequencer
// for the line memory.
// -----------------------------------------------------------------------------
`default_nettype none

module lsq_scan_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr,
	input  wire logic [lsq_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [lsq_pkg::SIDE_W-1:0]    cfg_val,
	input  wire logic                          step,
	output lsq_pkg::scan_pos_t                 pos,
	output logic                               run,
	output logic                               rd_en,
	output logic [lsq_pkg::POS_W-1:0]          rd_addr
);

	lsq_pkg::scan_state_t state_q, state_d;
	logic [lsq_pkg::SIDE_W-1:0] num_rows_q, num_cols_q;
	logic [lsq_pkg::POS_W-1:0]  row_q, col_q;
	logic                       restart;
	logic [lsq_pkg::SIDE_W-1:0] col_inc, row_inc;
	logic                       last_col, last_row;
	logic [lsq_pkg::POS_W-1:0]  col_next;

	assign restart  = cfg_wr && ((cfg_idx == lsq_pkg::REG_NUM_ROWS) ||
		(cfg_idx == lsq_pkg::REG_NUM_COLS));
	assign col_inc  = {1'b0, col_q} + lsq_pkg::SIDE_W'(1);
	assign row_inc  = {1'b0, row_q} + lsq_pkg::SIDE_W'(1);
	assign last_col = col_inc >= num_cols_q;
	assign last_row = row_inc >= num_rows_q;
	assign col_next = last_col ? '0 : col_inc[lsq_pkg::POS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= lsq_pkg::SIDE_W'(1);
			num_cols_q <= lsq_pkg::SIDE_W'(1);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				lsq_pkg::REG_NUM_ROWS:
					num_rows_q <= lsq_pkg::clamp_size(cfg_val, lsq_pkg::SIDE_W'(lsq_pkg::MAX_ROWS));
				lsq_pkg::REG_NUM_COLS:
					num_cols_q <= lsq_pkg::clamp_size(cfg_val, lsq_pkg::SIDE_W'(lsq_pkg::MAX_COLS));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (step) begin
			col_q <= col_next;
			if (last_col)
				row_q <= last_row ? '0 : row_inc[lsq_pkg::POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lsq_pkg::ST_PRIME;
		else
			state_q <= state_d;
	end

	// Prime the read of column zero, then read one column ahead on every cell
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = col_next;
		run     = 1'b0;
		unique case (state_q)
			lsq_pkg::ST_PRIME: begin
				rd_en   = 1'b1;
				rd_addr = '0;
				state_d = restart ? lsq_pkg::ST_PRIME : lsq_pkg::ST_RUN;
			end
			lsq_pkg::ST_RUN: begin
				run   = 1'b1;
				rd_en = step;
				if (restart)
					state_d = lsq_pkg::ST_PRIME;
			end
			default: state_d = lsq_pkg::ST_PRIME;
		endcase
	end

	assign pos.row       = row_q;
	assign pos.col       = col_q;
	assign pos.first_row = row_q == '0;
	assign pos.first_col = col_q == '0;
	assign pos.last_row  = last_row;
	assign pos.last_col  = last_col;
	assign pos.num_rows  = num_rows_q;
	assign pos.num_cols  = num_cols_q;

endmodule

`default_nettype wire

// File: rtl/largest_square_of_ones.sv
// -----------------------------------------------------------------------------
// largest_square_of_ones
// Streaming largest all-ones square finder over a binary grid.
// -----------------------------------------------------------------------------
// Cells arrive one per transaction in row-major order; num_rows x num_cols
// (clamped to 1..1024) sets the grid. Unless priming or held off, the block
// takes one cell per clock: the line memory of previous-row sides is read
// one column ahead, so each cell finds its upper neighbour waiting in the
// memory's read register. After reset and after each write to num_rows or
// num_cols the block primes that read before in_ready rises. After the last
// cell of a grid one result gives the best side and its bottom-right corner;
// the last cell of the next grid is held off while that result is still
// untaken. Such a write also restarts the grid.
`default_nettype none

module largest_square_of_ones (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lsq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lsq_pkg::SIDE_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          cell_value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [lsq_pkg::SIDE_W-1:0]    best_side,
	output logic      [lsq_pkg::POS_W-1:0]     corner_row,
	output logic      [lsq_pkg::POS_W-1:0]     corner_col
);

	lsq_pkg::scan_pos_t         pos;
	logic                       run, rd_en;
	logic [lsq_pkg::POS_W-1:0]  rd_addr;
	logic [lsq_pkg::SIDE_W-1:0] up;
	logic                       cfg_wr, restart, in_fire, grid_end;
	logic [lsq_pkg::SIDE_W-1:0] left_q, diag_q, best_q, side;
	logic [lsq_pkg::POS_W-1:0]  best_row_q, best_col_q;
	logic [lsq_pkg::SIDE_W-1:0] best_n;
	logic [lsq_pkg::POS_W-1:0]  best_row_n, best_col_n;
	logic                       out_valid_q;
	logic [lsq_pkg::SIDE_W-1:0] out_side_q;
	logic [lsq_pkg::POS_W-1:0]  out_row_q, out_col_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr && ((cfg_index == lsq_pkg::REG_NUM_ROWS) ||
		(cfg_index == lsq_pkg::REG_NUM_COLS));

	lsq_scan_ctrl u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_wr),
		.cfg_idx (cfg_index),
		.cfg_val (cfg_data),
		.step    (in_fire),
		.pos     (pos),
		.run     (run),
		.rd_en   (rd_en),
		.rd_addr (rd_addr)
	);

	lsq_line_mem u_line (
		.clk     (clk),
		.wr_en   (in_fire),
		.wr_addr (pos.col),
		.wr_data (side),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (up)
	);

	assign grid_end = pos.last_row && pos.last_col;
	assign in_ready = run && !(grid_end && out_valid_q);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		if (pos.first_row || pos.first_col)
			side = lsq_pkg::SIDE_W'(cell_value);
		else if (cell_value)
			side = lsq_pkg::min3(left_q, up, diag_q) + lsq_pkg::SIDE_W'(1);
		else
			side = '0;

		best_n     = best_q;
		best_row_n = best_row_q;
		best_col_n = best_col_q;
		if (side > best_q) begin
			best_n     = side;
			best_row_n = pos.row;
			best_col_n = pos.col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= '0;
			diag_q     <= '0;
			best_q     <= '0;
			best_row_q <= '0;
			best_col_q <= '0;
		end else if (restart) begin
			left_q     <= '0;
			diag_q     <= '0;
			best_q     <= '0;
			best_row_q <= '0;
			best_col_q <= '0;
		end else if (in_fire) begin
			if (pos.last_col) begin
				left_q <= '0;
				diag_q <= '0;
			end else begin
				left_q <= side;
				diag_q <= up;
			end
			if (grid_end) begin
				best_q     <= '0;
				best_row_q <= '0;
				best_col_q <= '0;
			end else begin
				best_q     <= best_n;
				best_row_q <= best_row_n;
				best_col_q <= best_col_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_fire && grid_end)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire && grid_end) begin
			out_side_q <= best_n;
			out_row_q  <= best_row_n;
			out_col_q  <= best_col_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign best_side  = out_side_q;
	assign corner_row = out_row_q;
	assign corner_col = out_col_q;

	// Last cell of a grid always yields a result next cycle
	a_grid_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && grid_end |=> out_valid)
		else $error("no result after last cell of grid");

	// Scan column stays inside the configured width
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		run |-> ({1'b0, pos.col} < pos.num_cols))
		else $error("scan column beyond num_cols");

	// A square must fit above and left of its corner
	a_square_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (best_side != '0) |->
		(({1'b0, corner_row} + lsq_pkg::SIDE_W'(1)) >= best_side) &&
		(({1'b0, corner_col} + lsq_pkg::SIDE_W'(1)) >= best_side))
		else $error("reported square does not fit at its corner");

endmodule

`default_nettype wire
